>>> rtl/rpc_pkg.sv
`default_nettype none
package rpc_pkg;

  localparam int CW = 32;          // coordinate width
  localparam int SW = 31;          // width / height width
  localparam int OW = CW + 1;      // point offset from corner
  localparam int DW = CW + 3;      // doubled offset from center
  localparam int AW = DW - 1;      // magnitude of doubled offset
  localparam int PW = AW + SW;     // cross product
  localparam int QW = SW;          // quotient bits
  localparam int HW = CW + 4;      // crossing coordinate in half units
  localparam int FW = HW - 1;      // crossing coordinate after flooring

  typedef enum logic [1:0] {
    CFG_RECT_X      = 2'd0,
    CFG_RECT_Y      = 2'd1,
    CFG_RECT_WIDTH  = 2'd2,
    CFG_RECT_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LOC_OUTSIDE = 2'd0,
    LOC_BORDER  = 2'd1,
    LOC_INSIDE  = 2'd2
  } loc_e;

  typedef struct packed {
    loc_e loc;
    logic vert;
    logic neg;
    logic steep;
  } tag_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
  } rect_t;

endpackage
`default_nettype wire

>>> rtl/rpc_front.sv
`default_nettype none
module rpc_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire logic                            valid_i,
  input  wire logic signed [rpc_pkg::CW-1:0]   px_i,
  input  wire logic signed [rpc_pkg::CW-1:0]   py_i,
  input  wire rpc_pkg::rect_t                  rect_i,
  output logic                                 valid_o,
  output rpc_pkg::tag_t                        tag_o,
  output logic [rpc_pkg::PW-1:0]               num_o,
  output logic [rpc_pkg::AW-1:0]               den_o
);

  // stage A: offsets
  logic                            a_valid_q;
  logic signed [rpc_pkg::OW-1:0]   ll_q, hh_q;
  logic signed [rpc_pkg::DW-1:0]   dx2_q, dy2_q;
  logic signed [rpc_pkg::OW-1:0]   ll_d, hh_d;
  logic signed [rpc_pkg::DW-1:0]   dx2_d, dy2_d;

  assign ll_d  = {px_i[rpc_pkg::CW-1], px_i} - {rect_i.x[rpc_pkg::CW-1], rect_i.x};
  assign hh_d  = {py_i[rpc_pkg::CW-1], py_i} - {rect_i.y[rpc_pkg::CW-1], rect_i.y};
  assign dx2_d = {{2{px_i[rpc_pkg::CW-1]}}, px_i, 1'b0}
               - {{2{rect_i.x[rpc_pkg::CW-1]}}, rect_i.x, 1'b0}
               - {4'b0000, rect_i.w};
  assign dy2_d = {{2{py_i[rpc_pkg::CW-1]}}, py_i, 1'b0}
               - {{2{rect_i.y[rpc_pkg::CW-1]}}, rect_i.y, 1'b0}
               - {4'b0000, rect_i.h};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ll_q  <= ll_d;
      hh_q  <= hh_d;
      dx2_q <= dx2_d;
      dy2_q <= dy2_d;
    end
  end

  // stage B: classify, magnitudes
  logic                            b_valid_q;
  rpc_pkg::loc_e                   b_loc_q, loc_d;
  logic                            b_vert_q, b_neg_q;
  logic [rpc_pkg::AW-1:0]          adx_q, ady_q;
  logic signed [rpc_pkg::OW-1:0]   w_s, h_s;
  logic signed [rpc_pkg::DW-1:0]   ndx, ndy;
  logic                            in_x, in_y, on_x, on_y, edge_x, edge_y;

  assign w_s = $signed({2'b00, rect_i.w});
  assign h_s = $signed({2'b00, rect_i.h});
  assign in_x   = (ll_q > 0) && (ll_q < w_s);
  assign in_y   = (hh_q > 0) && (hh_q < h_s);
  assign on_x   = (ll_q >= 0) && (ll_q <= w_s);
  assign on_y   = (hh_q >= 0) && (hh_q <= h_s);
  assign edge_x = (ll_q == 0) || (ll_q == w_s);
  assign edge_y = (hh_q == 0) || (hh_q == h_s);
  assign ndx = -dx2_q;
  assign ndy = -dy2_q;

  always_comb begin
    if (in_x && in_y) begin
      loc_d = rpc_pkg::LOC_INSIDE;
    end else if ((edge_x && on_y) || (on_x && edge_y)) begin
      loc_d = rpc_pkg::LOC_BORDER;
    end else begin
      loc_d = rpc_pkg::LOC_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_loc_q  <= loc_d;
      b_vert_q <= (dx2_q == 0);
      b_neg_q  <= dx2_q[rpc_pkg::DW-1] ^ dy2_q[rpc_pkg::DW-1];
      adx_q    <= dx2_q[rpc_pkg::DW-1] ? ndx[rpc_pkg::AW-1:0] : dx2_q[rpc_pkg::AW-1:0];
      ady_q    <= dy2_q[rpc_pkg::DW-1] ? ndy[rpc_pkg::AW-1:0] : dy2_q[rpc_pkg::AW-1:0];
    end
  end

  // stage C: cross products
  logic                     c_valid_q;
  rpc_pkg::loc_e            c_loc_q;
  logic                     c_vert_q, c_neg_q;
  logic [rpc_pkg::AW-1:0]   c_adx_q, c_ady_q;
  logic [rpc_pkg::PW-1:0]   p_yw_q, p_hx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_loc_q  <= b_loc_q;
      c_vert_q <= b_vert_q;
      c_neg_q  <= b_neg_q;
      c_adx_q  <= adx_q;
      c_ady_q  <= ady_q;
      p_yw_q   <= ady_q * {{(rpc_pkg::PW-rpc_pkg::SW){1'b0}}, rect_i.w};
      p_hx_q   <= adx_q * {{(rpc_pkg::PW-rpc_pkg::SW){1'b0}}, rect_i.h};
    end
  end

  // stage D: pick branch, set up the divide
  logic                     d_valid_q;
  rpc_pkg::tag_t            d_tag_q;
  logic [rpc_pkg::PW-1:0]   num_q;
  logic [rpc_pkg::AW-1:0]   den_q;
  logic                     steep;

  assign steep = p_yw_q > p_hx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (adv_i) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_tag_q.loc   <= c_loc_q;
      d_tag_q.vert  <= c_vert_q;
      d_tag_q.neg   <= c_neg_q;
      d_tag_q.steep <= steep;
      if (c_vert_q) begin
        // vertical line: keep the divider on a harmless operand
        num_q <= '0;
        den_q <= {{(rpc_pkg::AW-1){1'b0}}, 1'b1};
      end else if (steep) begin
        num_q <= p_hx_q;
        den_q <= c_ady_q;
      end else begin
        num_q <= p_yw_q;
        den_q <= c_adx_q;
      end
    end
  end

  assign valid_o = d_valid_q;
  assign tag_o   = d_tag_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

>>> rtl/rpc_div_stage.sv
`default_nettype none
module rpc_div_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      valid_i,
  input  wire rpc_pkg::tag_t             tag_i,
  input  wire logic [rpc_pkg::AW-1:0]    rem_i,
  input  wire logic [rpc_pkg::QW-1:0]    low_i,
  input  wire logic [rpc_pkg::QW-1:0]    quo_i,
  input  wire logic [rpc_pkg::AW-1:0]    den_i,
  output logic                           valid_o,
  output rpc_pkg::tag_t                  tag_o,
  output logic [rpc_pkg::AW-1:0]         rem_o,
  output logic [rpc_pkg::QW-1:0]         low_o,
  output logic [rpc_pkg::QW-1:0]         quo_o,
  output logic [rpc_pkg::AW-1:0]         den_o
);

  logic [rpc_pkg::AW:0]   trial, diff;
  logic                   ge;
  logic                   valid_q;
  rpc_pkg::tag_t          tag_q;
  logic [rpc_pkg::AW-1:0] rem_q, den_q;
  logic [rpc_pkg::QW-1:0] low_q, quo_q;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_i, low_i[rpc_pkg::QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q <= tag_i;
      den_q <= den_i;
      rem_q <= ge ? diff[rpc_pkg::AW-1:0] : trial[rpc_pkg::AW-1:0];
      low_q <= {low_i[rpc_pkg::QW-2:0], 1'b0};
      quo_q <= {quo_i[rpc_pkg::QW-2:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

>>> rtl/rpc_back.sv
`default_nettype none
module rpc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire rpc_pkg::tag_t                 tag_i,
  input  wire logic [rpc_pkg::QW-1:0]        quo_i,
  input  wire rpc_pkg::rect_t                rect_i,
  output logic                               valid_o,
  output logic [1:0]                         location_o,
  output logic signed [rpc_pkg::CW-1:0]      first_cross_x_o,
  output logic signed [rpc_pkg::CW-1:0]      first_cross_y_o,
  output logic signed [rpc_pkg::CW-1:0]      second_cross_x_o,
  output logic signed [rpc_pkg::CW-1:0]      second_cross_y_o,
  output logic                               saturated_o
);

  // stage E: crossing points in half units, floored
  logic signed [rpc_pkg::HW-1:0] x2, y2, wx, hx, w2, h2, cx, cy, qx, sq;
  logic signed [rpc_pkg::HW-1:0] ax, ay, bx, by;

  assign x2 = {{3{rect_i.x[rpc_pkg::CW-1]}}, rect_i.x, 1'b0};
  assign y2 = {{3{rect_i.y[rpc_pkg::CW-1]}}, rect_i.y, 1'b0};
  assign wx = {5'b00000, rect_i.w};
  assign hx = {5'b00000, rect_i.h};
  assign w2 = {4'b0000, rect_i.w, 1'b0};
  assign h2 = {4'b0000, rect_i.h, 1'b0};
  assign cx = x2 + wx;
  assign cy = y2 + hx;
  assign qx = {5'b00000, quo_i};
  assign sq = tag_i.neg ? -qx : qx;

  always_comb begin
    if (tag_i.vert) begin
      ax = cx;
      bx = cx;
      ay = y2;
      by = y2 + h2;
    end else if (tag_i.steep) begin
      ax = cx - sq;
      bx = cx + sq;
      ay = y2;
      by = y2 + h2;
    end else begin
      ax = x2;
      bx = x2 + w2;
      ay = cy - sq;
      by = cy + sq;
    end
  end

  logic                          e_valid_q;
  rpc_pkg::loc_e                 e_loc_q;
  logic signed [rpc_pkg::FW-1:0] e_ax_q, e_ay_q, e_bx_q, e_by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv_i) begin
      e_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_loc_q <= tag_i.loc;
      e_ax_q  <= ax[rpc_pkg::HW-1:1];
      e_ay_q  <= ay[rpc_pkg::HW-1:1];
      e_bx_q  <= bx[rpc_pkg::HW-1:1];
      e_by_q  <= by[rpc_pkg::HW-1:1];
    end
  end

  // stage F: order and clamp
  function automatic logic [rpc_pkg::CW:0] clamp(input logic [rpc_pkg::FW-1:0] v);
    logic [rpc_pkg::FW-rpc_pkg::CW:0] top;
    top = v[rpc_pkg::FW-1:rpc_pkg::CW-1];
    if ((&top) || !(|top)) begin
      clamp = {1'b0, v[rpc_pkg::CW-1:0]};
    end else if (v[rpc_pkg::FW-1]) begin
      clamp = {1'b1, 1'b1, {(rpc_pkg::CW-1){1'b0}}};
    end else begin
      clamp = {1'b1, 1'b0, {(rpc_pkg::CW-1){1'b1}}};
    end
  endfunction

  logic                          swap;
  logic signed [rpc_pkg::FW-1:0] fx, fy, sx, sy;
  logic [rpc_pkg::CW:0]          cfx, cfy, csx, csy;

  assign swap = (e_ax_q > e_bx_q) || ((e_ax_q == e_bx_q) && (e_ay_q > e_by_q));
  assign fx = swap ? e_bx_q : e_ax_q;
  assign fy = swap ? e_by_q : e_ay_q;
  assign sx = swap ? e_ax_q : e_bx_q;
  assign sy = swap ? e_ay_q : e_by_q;
  assign cfx = clamp(fx);
  assign cfy = clamp(fy);
  assign csx = clamp(sx);
  assign csy = clamp(sy);

  logic                         f_valid_q;
  logic [1:0]                   f_loc_q;
  logic [rpc_pkg::CW-1:0]       f_fx_q, f_fy_q, f_sx_q, f_sy_q;
  logic                         f_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv_i) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_loc_q <= e_loc_q;
      f_fx_q  <= cfx[rpc_pkg::CW-1:0];
      f_fy_q  <= cfy[rpc_pkg::CW-1:0];
      f_sx_q  <= csx[rpc_pkg::CW-1:0];
      f_sy_q  <= csy[rpc_pkg::CW-1:0];
      f_sat_q <= cfx[rpc_pkg::CW] | cfy[rpc_pkg::CW] | csx[rpc_pkg::CW] | csy[rpc_pkg::CW];
    end
  end

  assign valid_o          = f_valid_q;
  assign location_o       = f_loc_q;
  assign first_cross_x_o  = f_fx_q;
  assign first_cross_y_o  = f_fy_q;
  assign second_cross_x_o = f_sx_q;
  assign second_cross_y_o = f_sy_q;
  assign saturated_o      = f_sat_q;

endmodule
`default_nettype wire

>>> rtl/rect_point_classify_center_line_cross.sv
// Classifies query points against a rectangle held in four registers and
// finds where the line through the point and the rectangle center crosses
// the border.
// Input channel: in_valid_i / in_stall_o carry one point (point_x_i,
// point_y_i, signed Q16.16) per word. Output channel: out_valid_o /
// out_stall_i carry location, the two ordered crossing points and the
// saturated flag. A word moves on a rising edge with valid high, stall low.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (rect_x, rect_y, rect_width, rect_height); write only while no point is
// in flight.
// From acceptance to the result word there are four setup stages, one
// stage per quotient bit of the 31-step divider, then two stages to form,
// order and clamp the points. A point may enter every cycle while the
// output is not stalled; throughput is one word per cycle outside stalls.
// Reset empties the pipeline and loads a rectangle at the origin of size
// 1.0 by 1.0. When the receiver stalls a valid result, the whole pipeline
// holds and in_stall_o is raised; nothing is dropped or repeated.
`default_nettype none
module rect_point_classify_center_line_cross (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rpc_pkg::CW-1:0]        cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [rpc_pkg::CW-1:0] point_x_i,
  input  wire logic signed [rpc_pkg::CW-1:0] point_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         location_o,
  output logic signed [rpc_pkg::CW-1:0]      first_cross_x_o,
  output logic signed [rpc_pkg::CW-1:0]      first_cross_y_o,
  output logic signed [rpc_pkg::CW-1:0]      second_cross_x_o,
  output logic signed [rpc_pkg::CW-1:0]      second_cross_y_o,
  output logic                               saturated_o
);

  rpc_pkg::rect_t rect_q;
  logic           adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q.x <= '0;
      rect_q.y <= '0;
      rect_q.w <= rpc_pkg::SW'(65536);
      rect_q.h <= rpc_pkg::SW'(65536);
    end else if (cfg_we_i) begin
      case (rpc_pkg::cfg_idx_e'(cfg_idx_i))
        rpc_pkg::CFG_RECT_X:      rect_q.x <= cfg_data_i;
        rpc_pkg::CFG_RECT_Y:      rect_q.y <= cfg_data_i;
        rpc_pkg::CFG_RECT_WIDTH:  rect_q.w <= cfg_data_i[rpc_pkg::SW-1:0];
        rpc_pkg::CFG_RECT_HEIGHT: rect_q.h <= cfg_data_i[rpc_pkg::SW-1:0];
        default: ;
      endcase
    end
  end

  // hold every stage while the output word is stalled
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic                   dv   [rpc_pkg::QW+1];
  rpc_pkg::tag_t          dtag [rpc_pkg::QW+1];
  logic [rpc_pkg::AW-1:0] drem [rpc_pkg::QW+1];
  logic [rpc_pkg::QW-1:0] dlow [rpc_pkg::QW+1];
  logic [rpc_pkg::QW-1:0] dquo [rpc_pkg::QW+1];
  logic [rpc_pkg::AW-1:0] dden [rpc_pkg::QW+1];
  logic [rpc_pkg::PW-1:0] num;

  rpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .rect_i  (rect_q),
    .valid_o (dv[0]),
    .tag_o   (dtag[0]),
    .num_o   (num),
    .den_o   (dden[0])
  );

  assign drem[0] = num[rpc_pkg::PW-1:rpc_pkg::QW];
  assign dlow[0] = num[rpc_pkg::QW-1:0];
  assign dquo[0] = '0;

  for (genvar i = 0; i < rpc_pkg::QW; i++) begin : g_div
    rpc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv[i]),
      .tag_i   (dtag[i]),
      .rem_i   (drem[i]),
      .low_i   (dlow[i]),
      .quo_i   (dquo[i]),
      .den_i   (dden[i]),
      .valid_o (dv[i+1]),
      .tag_o   (dtag[i+1]),
      .rem_o   (drem[i+1]),
      .low_o   (dlow[i+1]),
      .quo_o   (dquo[i+1]),
      .den_o   (dden[i+1])
    );
  end

  rpc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .valid_i          (dv[rpc_pkg::QW]),
    .tag_i            (dtag[rpc_pkg::QW]),
    .quo_i            (dquo[rpc_pkg::QW]),
    .rect_i           (rect_q),
    .valid_o          (out_valid_o),
    .location_o       (location_o),
    .first_cross_x_o  (first_cross_x_o),
    .first_cross_y_o  (first_cross_y_o),
    .second_cross_x_o (second_cross_x_o),
    .second_cross_y_o (second_cross_y_o),
    .saturated_o      (saturated_o)
  );

endmodule
`default_nettype wire
